### design/cmr_pkg.sv
// Shared types and constants for the midpoint circle rasterizer.
// Used by the front end, the command queue, the pixel back end and the top level.
package cmr_pkg;

    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 80;
    localparam int OUT_USER_W = 2;

    localparam int CEN_W     = 15;
    localparam int RAD_W     = 12;
    localparam int COLOR_W   = 32;
    localparam int OFS_W     = 16;
    localparam int DIM_REG_W = 13;
    localparam int PIX_W     = 12;
    localparam int ADDR_W    = 24;
    localparam int STEP_W    = 14;
    localparam int DEC_W     = 18;
    // center plus offset plus step, signed
    localparam int CRD_W     = 18;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int MAX_RADIUS         = 4095;
    localparam int MAX_SCREEN_DIM_DEF = 4096;

    localparam int QUEUE_DEPTH = 2;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // decision variable constants of the midpoint method
    localparam int DEC_INIT = 3;
    localparam int DEC_DIAG = 10;
    localparam int DEC_AXIS = 6;

    localparam logic REQ_START   = 1'b0;
    localparam logic REQ_ADVANCE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y      = 2'd3;

    localparam logic [DIM_REG_W-1:0] SCREEN_WIDTH_RST  = 13'd1280;
    localparam logic [DIM_REG_W-1:0] SCREEN_HEIGHT_RST = 13'd720;

    // One drawing command: eight pixels around a base point, or a single
    // invisible result for a circle that lies off screen.
    typedef struct packed {
        logic                       single;
        logic signed [CRD_W-1:0]    base_x;
        logic signed [CRD_W-1:0]    base_y;
        logic signed [STEP_W-1:0]   step_x;
        logic signed [STEP_W-1:0]   step_y;
        logic [COLOR_W-1:0]         color;
        logic                       done;
    } cmr_cmd_t;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QCNT_W-1:0] count;
    } cmr_qstat_t;

endpackage

### design/cmr_front.sv
// Front end: accepts start and advance requests, runs the midpoint decision step
// and pushes one command per start or running-circle advance. Depends on cmr_pkg.
module cmr_front
    import cmr_pkg::*;
#(
    parameter int MAX_SCREEN_DIM = MAX_SCREEN_DIM_DEF
)
(
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        s_tvalid,
    output logic                                        s_tready,
    input  logic [IN_DATA_W-1:0]                        s_tdata,
    input  logic                                        s_tuser,
    input  logic signed [OFS_W-1:0]                     offset_x,
    input  logic signed [OFS_W-1:0]                     offset_y,
    input  logic [$clog2(MAX_SCREEN_DIM + 1)-1:0]       scr_w,
    input  logic [$clog2(MAX_SCREEN_DIM + 1)-1:0]       scr_h,
    input  logic                                        q_full,
    output logic                                        push,
    output cmr_cmd_t                                    cmd
);

    logic signed [CEN_W-1:0]  cen_x_reg, cen_x_next;
    logic signed [CEN_W-1:0]  cen_y_reg, cen_y_next;
    logic signed [STEP_W-1:0] step_x_reg, step_x_next;
    logic signed [STEP_W-1:0] step_y_reg, step_y_next;
    logic signed [DEC_W-1:0]  decision_reg, decision_next;
    logic [COLOR_W-1:0]       color_reg, color_next;
    logic                     lock_reg, lock_next;
    logic                     active_reg, active_next;

    logic                     accept;
    logic                     is_start;
    logic signed [CEN_W-1:0]  in_cx;
    logic signed [CEN_W-1:0]  in_cy;
    logic [RAD_W-1:0]         in_r;
    logic                     in_lock;
    logic [COLOR_W-1:0]       in_color;
    logic [RAD_W-1:0]         r_sat;

    logic signed [CRD_W-1:0]  cx_ext, cy_ext, r_ext, ox_ext, oy_ext, w_ext, h_ext;
    logic signed [CRD_W-1:0]  right_x, left_x, bottom_y, top_y;
    logic                     off_screen;

    logic signed [STEP_W-1:0] adv_x, adv_y;
    logic                     dec_pos;
    logic signed [DEC_W-1:0]  diff_ext, nx_ext;
    logic signed [DEC_W-1:0]  adv_dec;
    logic                     adv_done;

    logic                     use_lock;
    logic signed [CRD_W-1:0]  base_cx, base_cy;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign is_start = (s_tuser == REQ_START);

    assign in_cx    = s_tdata[14:0];
    assign in_cy    = s_tdata[29:15];
    assign in_r     = s_tdata[41:30];
    assign in_lock  = s_tdata[42];
    assign in_color = s_tdata[74:43];

    assign r_sat = (int'(in_r) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : in_r;

    // Off-screen test always includes the scroll offset.
    assign cx_ext = CRD_W'(in_cx);
    assign cy_ext = CRD_W'(in_cy);
    assign r_ext  = signed'(CRD_W'(r_sat));
    assign ox_ext = CRD_W'(offset_x);
    assign oy_ext = CRD_W'(offset_y);
    assign w_ext  = signed'(CRD_W'(scr_w));
    assign h_ext  = signed'(CRD_W'(scr_h));

    assign right_x  = cx_ext + r_ext + ox_ext;
    assign left_x   = cx_ext - r_ext + ox_ext;
    assign bottom_y = cy_ext + r_ext + oy_ext;
    assign top_y    = cy_ext - r_ext + oy_ext;

    assign off_screen = right_x[CRD_W-1] || (left_x > w_ext)
                     || bottom_y[CRD_W-1] || (top_y > h_ext);

    // One midpoint step from the held point.
    assign adv_x    = step_x_reg + STEP_W'(1);
    assign dec_pos  = !decision_reg[DEC_W-1] && (decision_reg != '0);
    assign adv_y    = dec_pos ? (step_y_reg - STEP_W'(1)) : step_y_reg;
    assign diff_ext = DEC_W'(adv_x - adv_y);
    assign nx_ext   = DEC_W'(adv_x);
    assign adv_dec  = dec_pos ? (decision_reg + (diff_ext <<< 2) + DEC_W'(DEC_DIAG))
                              : (decision_reg + (nx_ext <<< 2) + DEC_W'(DEC_AXIS));
    assign adv_done = (adv_y < adv_x);

    always_comb
    begin
        cen_x_next    = cen_x_reg;
        cen_y_next    = cen_y_reg;
        step_x_next   = step_x_reg;
        step_y_next   = step_y_reg;
        decision_next = decision_reg;
        color_next    = color_reg;
        lock_next     = lock_reg;
        active_next   = active_reg;
        if (accept)
        begin
            if (is_start)
            begin
                cen_x_next  = in_cx;
                cen_y_next  = in_cy;
                color_next  = in_color;
                lock_next   = in_lock;
                active_next = !off_screen;
                if (!off_screen)
                begin
                    step_x_next   = '0;
                    step_y_next   = signed'(STEP_W'(r_sat));
                    decision_next = DEC_W'(DEC_INIT) - signed'(DEC_W'({r_sat, 1'b0}));
                end
            end
            else if (active_reg)
            begin
                step_x_next   = adv_x;
                step_y_next   = adv_y;
                decision_next = adv_dec;
                active_next   = !adv_done;
            end
        end
    end

    // Drop advances that arrive with no circle in progress.
    assign push = accept && (is_start || active_reg);

    assign use_lock = is_start ? in_lock : lock_reg;
    assign base_cx  = is_start ? cx_ext : CRD_W'(cen_x_reg);
    assign base_cy  = is_start ? cy_ext : CRD_W'(cen_y_reg);

    always_comb
    begin
        cmd.single = is_start && off_screen;
        cmd.base_x = use_lock ? base_cx : (base_cx + ox_ext);
        cmd.base_y = use_lock ? base_cy : (base_cy + oy_ext);
        cmd.step_x = step_x_next;
        cmd.step_y = step_y_next;
        cmd.color  = is_start ? in_color : color_reg;
        cmd.done   = is_start ? off_screen : adv_done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cen_x_reg    <= '0;
            cen_y_reg    <= '0;
            step_x_reg   <= '0;
            step_y_reg   <= '0;
            decision_reg <= '0;
            color_reg    <= '0;
            lock_reg     <= 1'b0;
            active_reg   <= 1'b0;
        end
        else
        begin
            cen_x_reg    <= cen_x_next;
            cen_y_reg    <= cen_y_next;
            step_x_reg   <= step_x_next;
            step_y_reg   <= step_y_next;
            decision_reg <= decision_next;
            color_reg    <= color_next;
            lock_reg     <= lock_next;
            active_reg   <= active_next;
        end
    end

endmodule

### design/cmr_queue.sv
// Short command queue between the front end and the pixel back end.
// Depends on cmr_pkg for the command type and depth.
module cmr_queue
    import cmr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  cmr_cmd_t    push_cmd,
    input  logic        pop,
    output cmr_cmd_t    head_cmd,
    output cmr_qstat_t  stat
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    cmr_cmd_t          entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wptr_reg, wptr_next;
    logic [PTR_W-1:0]  rptr_reg, rptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wptr_next = (wptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rptr_next = (rptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wptr_reg] <= push_cmd;
        end
    end

    assign head_cmd   = entry_reg[rptr_reg];
    assign stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign stat.count = count_reg;

endmodule

### design/cmr_back.sv
// Pixel back end: walks the eight symmetric points of a command (one if single),
// clips them, forms the frame buffer address in a two-stage pipeline. Uses cmr_pkg.
module cmr_back
    import cmr_pkg::*;
#(
    parameter int MAX_SCREEN_DIM = MAX_SCREEN_DIM_DEF
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cmd_valid,
    input  cmr_cmd_t                                cmd,
    output logic                                    cmd_pop,
    input  logic [$clog2(MAX_SCREEN_DIM + 1)-1:0]   scr_w,
    input  logic [$clog2(MAX_SCREEN_DIM + 1)-1:0]   scr_h,
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    output logic [OUT_DATA_W-1:0]                   m_tdata,
    output logic [OUT_USER_W-1:0]                   m_tuser,
    output logic                                    m_tlast
);

    localparam int DIM_W = $clog2(MAX_SCREEN_DIM + 1);
    localparam int CW    = $clog2(MAX_SCREEN_DIM);
    localparam int PW    = CW + DIM_W;
    localparam int EXT_W = (PW > ADDR_W) ? PW : ADDR_W;

    logic [2:0]               k_reg, k_next;
    logic                     s1_valid_reg, s1_valid_next;
    logic [CW-1:0]            s1_x_reg;
    logic [CW-1:0]            s1_y_reg;
    logic                     s1_vis_reg;
    logic [COLOR_W-1:0]       s1_color_reg;
    logic                     s1_last_reg;
    logic                     s1_done_reg;

    logic                     out_valid_reg, out_valid_next;
    logic [PIX_W-1:0]         out_x_reg;
    logic [PIX_W-1:0]         out_y_reg;
    logic [ADDR_W-1:0]        out_addr_reg;
    logic [COLOR_W-1:0]       out_color_reg;
    logic                     out_vis_reg;
    logic                     out_last_reg;
    logic                     out_done_reg;

    logic                     s2_adv;
    logic                     s1_adv;
    logic                     issue;
    logic                     last_pix;
    logic signed [STEP_W-1:0] dx, dy;
    logic signed [CRD_W-1:0]  dx_ext, dy_ext;
    logic signed [CRD_W-1:0]  px, py;
    logic signed [CRD_W-1:0]  w_ext, h_ext;
    logic                     vis;
    logic [EXT_W-1:0]         addr_full;

    assign s2_adv   = !out_valid_reg || m_tready;
    assign s1_adv   = !s1_valid_reg || s2_adv;
    assign issue    = cmd_valid && s1_adv;
    assign last_pix = cmd.single || (k_reg == 3'd7);
    assign cmd_pop  = issue && last_pix;

    always_comb
    begin
        k_next = k_reg;
        if (issue)
        begin
            k_next = last_pix ? 3'd0 : (k_reg + 3'd1);
        end
    end

    // Upper four points swap the roles of x and y; bit 0 mirrors x, bit 1 mirrors y.
    assign dx     = k_reg[2] ? $signed(cmd.step_y) : $signed(cmd.step_x);
    assign dy     = k_reg[2] ? $signed(cmd.step_x) : $signed(cmd.step_y);
    assign dx_ext = CRD_W'(dx);
    assign dy_ext = CRD_W'(dy);
    assign px     = $signed(cmd.base_x) + (k_reg[0] ? -dx_ext : dx_ext);
    assign py     = $signed(cmd.base_y) + (k_reg[1] ? -dy_ext : dy_ext);
    assign w_ext  = signed'(CRD_W'(scr_w));
    assign h_ext  = signed'(CRD_W'(scr_h));
    assign vis    = !cmd.single && !px[CRD_W-1] && (px < w_ext)
                 && !py[CRD_W-1] && (py < h_ext);

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (issue)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s2_adv)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s2_adv)
        begin
            out_valid_next = s1_valid_reg;
        end
    end

    // Hidden pixels carry zero coordinates, so their address comes out zero too.
    assign addr_full = EXT_W'(s1_x_reg) + EXT_W'(s1_y_reg) * EXT_W'(scr_w);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg         <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            k_reg         <= k_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_x_reg     <= vis ? px[CW-1:0] : '0;
            s1_y_reg     <= vis ? py[CW-1:0] : '0;
            s1_vis_reg   <= vis;
            s1_color_reg <= cmd.color;
            s1_last_reg  <= last_pix;
            s1_done_reg  <= cmd.done;
        end
        if (s2_adv && s1_valid_reg)
        begin
            out_x_reg     <= PIX_W'(s1_x_reg);
            out_y_reg     <= PIX_W'(s1_y_reg);
            out_addr_reg  <= addr_full[ADDR_W-1:0];
            out_color_reg <= s1_color_reg;
            out_vis_reg   <= s1_vis_reg;
            out_last_reg  <= s1_last_reg;
            out_done_reg  <= s1_done_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_color_reg, out_addr_reg, out_y_reg, out_x_reg};
    assign m_tuser  = {out_done_reg, out_vis_reg};
    assign m_tlast  = out_last_reg;

endmodule

### design/midpoint_circle_rasterizer.sv
// Top level of the midpoint circle rasterizer: configuration registers,
// front end, command queue and pixel back end. Depends on cmr_pkg.
//
// Usage:
//   Input stream s_*: s_tuser selects start (0) or advance (1); s_tdata
//   carries center, radius, lock flag and color, used on start only.
//   A start of an off-screen circle yields one invisible result that closes
//   the circle; any other start, and each advance while a circle is running,
//   yields eight pixel transfers, the eighth marked by m_tlast. An advance
//   with no circle running yields nothing.
//   Output stream m_*: pixel column, row, frame buffer address and color in
//   m_tdata; m_tuser carries visible and circle_done.
//   Configuration: cfg_valid/cfg_index/cfg_data write screen width, height
//   and scroll offsets; cfg_ready is always high.
// Timing:
//   m_tvalid for the first pixel of a request rises once its command has passed
//   the queue entry, the s1 stage registers and the output registers.
//   The back end issues one pixel per cycle while m_tready lets it; a two-entry
//   command queue lets the next request be taken while the current one is drawn.
//   When m_tready is low the output and pipeline registers hold; once the
//   queue fills, s_tready drops. Reset clears control state but not data
//   registers, and restores the defaults (width 1280, height 720, offsets 0).
module midpoint_circle_rasterizer
    import cmr_pkg::*;
#(
    parameter int MAX_SCREEN_DIM = MAX_SCREEN_DIM_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // [14:0] center_x, [29:15] center_y, [41:30] radius, [42] lock_to_screen,
    // [74:43] pen_color, [79:75] zero
    input  logic [IN_DATA_W-1:0]    s_tdata,
    // [0] req_type
    input  logic                    s_tuser,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // [11:0] pix_x, [23:12] pix_y, [47:24] pix_addr, [79:48] pix_color
    output logic [OUT_DATA_W-1:0]   m_tdata,
    // [0] visible, [1] circle_done
    output logic [OUT_USER_W-1:0]   m_tuser,
    output logic                    m_tlast,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data
);

    localparam int DIM_W = $clog2(MAX_SCREEN_DIM + 1);

    logic [DIM_REG_W-1:0]    scr_w_reg, scr_w_next;
    logic [DIM_REG_W-1:0]    scr_h_reg, scr_h_next;
    logic signed [OFS_W-1:0] ofs_x_reg, ofs_x_next;
    logic signed [OFS_W-1:0] ofs_y_reg, ofs_y_next;

    logic [DIM_W-1:0]        eff_w, eff_h;
    logic                    q_push;
    logic                    q_pop;
    cmr_cmd_t                push_cmd;
    cmr_cmd_t                head_cmd;
    cmr_qstat_t              q_stat;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        scr_w_next = scr_w_reg;
        scr_h_next = scr_h_reg;
        ofs_x_next = ofs_x_reg;
        ofs_y_next = ofs_y_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SCREEN_WIDTH:  scr_w_next = cfg_data[DIM_REG_W-1:0];
                REG_SCREEN_HEIGHT: scr_h_next = cfg_data[DIM_REG_W-1:0];
                REG_OFFSET_X:      ofs_x_next = cfg_data;
                REG_OFFSET_Y:      ofs_y_next = cfg_data;
                default:           scr_w_next = scr_w_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scr_w_reg <= SCREEN_WIDTH_RST;
            scr_h_reg <= SCREEN_HEIGHT_RST;
            ofs_x_reg <= '0;
            ofs_y_reg <= '0;
        end
        else
        begin
            scr_w_reg <= scr_w_next;
            scr_h_reg <= scr_h_next;
            ofs_x_reg <= ofs_x_next;
            ofs_y_reg <= ofs_y_next;
        end
    end

    // Saturate screen dimensions to the largest supported size.
    assign eff_w = (int'(scr_w_reg) > MAX_SCREEN_DIM) ? DIM_W'(MAX_SCREEN_DIM)
                                                      : DIM_W'(scr_w_reg);
    assign eff_h = (int'(scr_h_reg) > MAX_SCREEN_DIM) ? DIM_W'(MAX_SCREEN_DIM)
                                                      : DIM_W'(scr_h_reg);

    cmr_front #(
        .MAX_SCREEN_DIM (MAX_SCREEN_DIM)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .offset_x (ofs_x_reg),
        .offset_y (ofs_y_reg),
        .scr_w    (eff_w),
        .scr_h    (eff_h),
        .q_full   (q_stat.full),
        .push     (q_push),
        .cmd      (push_cmd)
    );

    cmr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .head_cmd (head_cmd),
        .stat     (q_stat)
    );

    cmr_back #(
        .MAX_SCREEN_DIM (MAX_SCREEN_DIM)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (!q_stat.empty),
        .cmd       (head_cmd),
        .cmd_pop   (q_pop),
        .scr_w     (eff_w),
        .scr_h     (eff_h),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // A start always leaves a command waiting for the back end.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser == REQ_START)) |=> !q_stat.empty)
        else $error("start transfer did not queue a command");

    // Hidden pixels report zero coordinates and address.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata[47:0] == '0))
        else $error("hidden pixel with nonzero position");

    assert property (@(posedge clk) disable iff (!rst_n)
        (q_stat.count <= QCNT_W'(QUEUE_DEPTH)) && !(q_push && q_stat.full))
        else $error("command queue overflow");

endmodule

### bench/tb_midpoint_circle_rasterizer.sv
// Self-checking testbench for the midpoint circle rasterizer: directed circles,
// clipping and offset cases, back-pressure and random circle sequences.
// Depends on cmr_pkg and midpoint_circle_rasterizer.
`timescale 1ns / 100ps

module tb_midpoint_circle_rasterizer;

    import cmr_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 16;
    localparam int HOLD_CYCLES  = 300;

    typedef struct packed {
        logic [PIX_W-1:0]   col;
        logic [PIX_W-1:0]   row;
        logic [ADDR_W-1:0]  addr;
        logic [COLOR_W-1:0] color;
        logic               visible;
        logic               last;
        logic               done;
    } pixel_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [OUT_USER_W-1:0] m_tuser;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // mirror of the register file
    logic [DIM_REG_W-1:0]   view_width_reg  = SCREEN_WIDTH_RST;
    logic [DIM_REG_W-1:0]   view_height_reg = SCREEN_HEIGHT_RST;
    logic signed [OFS_W-1:0] scroll_x = '0;
    logic signed [OFS_W-1:0] scroll_y = '0;

    // circle being traced
    int                 arc_cx      = 0;
    int                 arc_cy      = 0;
    int                 arc_px      = 0;
    int                 arc_py      = 0;
    int                 arc_err     = 0;
    logic [COLOR_W-1:0] arc_color   = '0;
    logic               arc_lock    = 1'b0;
    logic               arc_running = 1'b0;

    pixel_t      expected_pixels[$];
    int          drawn_items    = 0;
    int          mismatch_count = 0;
    int          cycle_count    = 0;
    int unsigned snd_idle_pct   = 0;
    int unsigned rcv_idle_pct   = 0;
    logic        hold_off       = 1'b0;
    event        hold_off_go;

    midpoint_circle_rasterizer i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_midpoint_circle_rasterizer: FAIL");
            $finish;
        end
    end

    // ---------------------------------------------------------------- predictor

    function automatic int dim_limit(logic [DIM_REG_W-1:0] v);
        return (v > MAX_SCREEN_DIM_DEF) ? MAX_SCREEN_DIM_DEF : int'(v);
    endfunction

    function automatic void expect_pixel(int px, int py, logic last, logic done);
        int     w;
        int     h;
        pixel_t p;
        w = dim_limit(view_width_reg);
        h = dim_limit(view_height_reg);
        p = '0;
        p.color   = arc_color;
        p.last    = last;
        p.done    = done;
        p.visible = (px >= 0 && px < w && py >= 0 && py < h);
        if (p.visible)
        begin
            p.col  = px[PIX_W-1:0];
            p.row  = py[PIX_W-1:0];
            p.addr = ADDR_W'(px + py * w);
        end
        expected_pixels.push_back(p);
    endfunction

    // eight mirror images of the current octant point
    function automatic void expect_octants(logic done);
        int ox;
        int oy;
        int dx;
        int dy;
        int k;
        ox = arc_lock ? 0 : int'(scroll_x);
        oy = arc_lock ? 0 : int'(scroll_y);
        for (k = 0; k < 8; k++)
        begin
            dx = (k < 4) ? arc_px : arc_py;
            dy = (k < 4) ? arc_py : arc_px;
            expect_pixel(arc_cx + (k[0] ? -dx : dx) + ox, arc_cy + (k[1] ? -dy : dy) + oy,
                         k == 7, done);
        end
    endfunction

    function automatic void predict_request(logic req, logic [IN_DATA_W-1:0] d);
        int     cx;
        int     cy;
        int     r;
        int     ox;
        int     oy;
        pixel_t lone;
        if (req == REQ_START)
        begin
            cx = int'($signed(d[14:0]));
            cy = int'($signed(d[29:15]));
            r  = int'(d[41:30]);
            if (r > MAX_RADIUS)
                r = MAX_RADIUS;
            ox = int'(scroll_x);
            oy = int'(scroll_y);
            arc_color = d[74:43];
            arc_lock  = d[42];
            arc_cx    = cx;
            arc_cy    = cy;
            drawn_items++;
            // off-screen test takes the offset even for locked circles
            if (cx + r + ox < 0 || cx - r + ox > dim_limit(view_width_reg) ||
                cy + r + oy < 0 || cy - r + oy > dim_limit(view_height_reg))
            begin
                arc_running = 1'b0;
                lone = '0;
                lone.color = arc_color;
                lone.last  = 1'b1;
                lone.done  = 1'b1;
                expected_pixels.push_back(lone);
            end
            else
            begin
                arc_px      = 0;
                arc_py      = r;
                arc_err     = DEC_INIT - 2 * r;
                arc_running = 1'b1;
                expect_octants(1'b0);
            end
        end
        else if (arc_running)
        begin
            drawn_items++;
            arc_px++;
            if (arc_err > 0)
            begin
                arc_py--;
                arc_err += 4 * (arc_px - arc_py) + DEC_DIAG;
            end
            else
                arc_err += 4 * arc_px + DEC_AXIS;
            // the step that crosses the diagonal is still drawn
            if (arc_py < arc_px)
                arc_running = 1'b0;
            expect_octants(!arc_running);
        end
    endfunction

    function automatic void apply_register(logic [CFG_IDX_W-1:0] idx,
                                           logic [CFG_DATA_W-1:0] value);
        case (idx)
            REG_SCREEN_WIDTH:  view_width_reg  = value[DIM_REG_W-1:0];
            REG_SCREEN_HEIGHT: view_height_reg = value[DIM_REG_W-1:0];
            REG_OFFSET_X:      scroll_x        = value;
            REG_OFFSET_Y:      scroll_y        = value;
            default: ;
        endcase
    endfunction

    always @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            predict_request(s_tuser, s_tdata);
        if (cfg_valid && cfg_ready)
            apply_register(cfg_index, cfg_data);
    end

    // ----------------------------------------------------------------- checker

    function automatic void check_field(string field, longint unsigned want,
                                        longint unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk)
    begin : pixel_check
        pixel_t want;
        if (m_tvalid && m_tready)
        begin
            if (expected_pixels.size() == 0)
            begin
                $display("%0t: unexpected pixel, expected none, got tdata 0x%0h tuser 0x%0h",
                         $time, m_tdata, m_tuser);
                mismatch_count++;
            end
            else
            begin
                want = expected_pixels.pop_front();
                check_field("pix_x",        want.col,     m_tdata[11:0]);
                check_field("pix_y",        want.row,     m_tdata[23:12]);
                check_field("pix_addr",     want.addr,    m_tdata[47:24]);
                check_field("pix_color",    want.color,   m_tdata[79:48]);
                check_field("visible",      want.visible, m_tuser[0]);
                check_field("circle_done",  want.done,    m_tuser[1]);
                check_field("last_of_step", want.last,    m_tlast);
            end
        end
    end

    // ----------------------------------------------------------- receiver side

    always @(posedge clk)
        m_tready <= !hold_off && ($urandom_range(0, 99) >= rcv_idle_pct);

    // long receiver stall, counted here so the sender keeps offering meanwhile
    initial
    forever
    begin
        @(hold_off_go);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // ------------------------------------------------------------ sender side

    function automatic logic [IN_DATA_W-1:0] circle_word(int cx, int cy, int r, logic lock,
                                                         logic [COLOR_W-1:0] color);
        logic [IN_DATA_W-1:0] word;
        word = '0;
        word[14:0]  = cx[CEN_W-1:0];
        word[29:15] = cy[CEN_W-1:0];
        word[41:30] = r[RAD_W-1:0];
        word[42]    = lock;
        word[74:43] = color;
        return word;
    endfunction

    task automatic send_request(logic req, logic [IN_DATA_W-1:0] payload);
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= payload;
        do @(posedge clk); while (!s_tready);
        if ($urandom_range(0, 99) < snd_idle_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic wait_for_idle();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (expected_pixels.size() != 0);
        // an ignored advance may still be in flight
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // bits above the 13-bit dimension registers are don't-care, so randomize them
    task automatic set_view(int w, int h, int ox, int oy);
        write_register(REG_SCREEN_WIDTH,  {3'($urandom()), 13'(w)});
        write_register(REG_SCREEN_HEIGHT, {3'($urandom()), 13'(h)});
        write_register(REG_OFFSET_X,      16'(ox));
        write_register(REG_OFFSET_Y,      16'(oy));
    endtask

    task automatic draw_random_circle();
        int                   kind;
        int                   r;
        int                   cx;
        int                   cy;
        int                   steps;
        int                   k;
        logic [IN_DATA_W-1:0] noise;
        kind = $urandom_range(0, 15);
        if (kind < 11)
            r = $urandom_range(0, 12);
        else if (kind < 14)
            r = $urandom_range(13, 40);
        else
            r = $urandom_range(0, 4095);
        if ($urandom_range(0, 7) == 0)
        begin
            cx = $urandom();
            cy = $urandom();
        end
        else
        begin
            // aim around the visible window so edges get crossed
            cx = int'($urandom_range(0, dim_limit(view_width_reg) + 2 * r + 8))
                 - r - 4 - int'(scroll_x);
            cy = int'($urandom_range(0, dim_limit(view_height_reg) + 2 * r + 8))
                 - r - 4 - int'(scroll_y);
        end
        // enough advances to finish small circles; huge ones get abandoned
        steps = (kind < 14) ? (3 * r) / 4 + 2 : $urandom_range(0, 6);
        if ($urandom_range(0, 4) == 0)
            steps = $urandom_range(0, steps);
        send_request(REQ_START, circle_word(cx, cy, r, 1'($urandom()), $urandom()));
        for (k = 0; k < steps; k++)
        begin
            noise = {$urandom(), $urandom(), 16'($urandom())};
            noise[IN_DATA_W-1:75] = '0;
            send_request(REQ_ADVANCE, noise);
        end
    endtask

    task automatic run_random_items(int goal);
        int stop_at;
        stop_at = drawn_items + goal;
        while (drawn_items < stop_at)
            draw_random_circle();
        wait_for_idle();
    endtask

    // ------------------------------------------------------------------- tests

    task automatic test_directed_basics();
        logic [COLOR_W-1:0] paint;
        paint = $urandom();
        send_request(REQ_ADVANCE, '0);
        // single visible pixel group in the far corner
        send_request(REQ_START, circle_word(1279, 719, 0, 1'b1, 32'hFFFF_FFFF));
        send_request(REQ_ADVANCE, '0);
        send_request(REQ_START, circle_word(0, 0, 3, 1'b0, 32'h0000_0000));
        repeat (3) send_request(REQ_ADVANCE, {5'b0, {75{1'b1}}});
        send_request(REQ_START, circle_word(1279, 719, 4095, 1'b0, paint));
        send_request(REQ_ADVANCE, '0);
        // abandon the big circle with one that is off screen
        send_request(REQ_START, circle_word(-16384, -16384, 0, 1'b0, paint));
        send_request(REQ_START, circle_word(16383, 16383, 4095, 1'b1, ~paint));
        // circles touching the window bounds exactly still draw
        send_request(REQ_START, circle_word(1285, 100, 5, 1'b0, paint));
        send_request(REQ_START, circle_word(100, -5, 5, 1'b0, paint));
        send_request(REQ_START, circle_word(100, 725, 5, 1'b0, paint));
        wait_for_idle();
    endtask

    task automatic test_offset_and_lock();
        set_view(1280, 720, -100, 0);
        // locked, but the offset still pushes it off screen
        send_request(REQ_START, circle_word(50, 50, 10, 1'b1, $urandom()));
        wait_for_idle();
        set_view(1280, 720, -20, 7);
        send_request(REQ_START, circle_word(30, 30, 5, 1'b1, $urandom()));
        send_request(REQ_ADVANCE, '0);
        send_request(REQ_START, circle_word(30, 30, 5, 1'b0, $urandom()));
        send_request(REQ_ADVANCE, '0);
        wait_for_idle();
    endtask

    task automatic test_screen_extremes();
        set_view(0, 720, 0, 0);
        send_request(REQ_START, circle_word(0, 0, 0, 1'b0, $urandom()));
        wait_for_idle();
        set_view(5, 0, 0, 0);
        send_request(REQ_START, circle_word(2, 0, 0, 1'b0, $urandom()));
        wait_for_idle();
        // width register above the limit saturates
        set_view(8191, 4096, 0, 0);
        send_request(REQ_START, circle_word(4000, 4000, 200, 1'b0, $urandom()));
        send_request(REQ_ADVANCE, '0);
        wait_for_idle();
        set_view(1280, 720, 32767, -32768);
        send_request(REQ_START, circle_word(0, 0, 10, 1'b0, $urandom()));
        wait_for_idle();
        set_view(1, 1, 0, 0);
        send_request(REQ_START, circle_word(0, 0, 1, 1'b0, $urandom()));
        send_request(REQ_ADVANCE, '0);
        wait_for_idle();
    endtask

    task automatic test_backpressure();
        int k;
        set_view(1280, 720, 0, 0);
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        -> hold_off_go;
        // keep offering while the output is blocked so the input stalls
        send_request(REQ_START, circle_word(600, 300, 14, 1'b0, $urandom()));
        for (k = 0; k < 12; k++)
            send_request(REQ_ADVANCE, '0);
        wait_for_idle();
    endtask

    task automatic test_random_small_screen();
        snd_idle_pct = 23;
        rcv_idle_pct = 51;
        set_view($urandom_range(16, 160), $urandom_range(16, 120),
                 int'($urandom_range(0, 40)) - 20, int'($urandom_range(0, 40)) - 20);
        run_random_items(30);
    endtask

    task automatic test_random_wide_screen();
        snd_idle_pct = 51;
        rcv_idle_pct = 23;
        set_view($urandom_range(0, 8191), $urandom_range(0, 8191),
                 int'($urandom_range(0, 4095)) - 2048, int'($urandom_range(0, 4095)) - 2048);
        run_random_items(30);
    endtask

    task automatic test_random_full_rate();
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        set_view($urandom_range(200, 1000), $urandom_range(100, 700),
                 int'($urandom_range(0, 200)) - 100, int'($urandom_range(0, 200)) - 100);
        run_random_items(30);
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_basics();
        test_offset_and_lock();
        test_screen_extremes();
        test_backpressure();
        test_random_small_screen();
        test_random_wide_screen();
        test_random_full_rate();
        if (mismatch_count == 0 && expected_pixels.size() == 0)
            $display("tb_midpoint_circle_rasterizer: PASS");
        else
            $display("tb_midpoint_circle_rasterizer: FAIL");
        $finish;
    end

endmodule
